>>> hw/rtl/rgb_3x3_convolution_filter_core_macros.svh
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter - assertion macros
// Shared wrappers for the concurrent assertions of the filter core.
// ----------------------------------------------------------------------------
`ifndef RGB_3X3_CONVOLUTION_FILTER_CORE_MACROS_SVH
`define RGB_3X3_CONVOLUTION_FILTER_CORE_MACROS_SVH

// Checked on every rising edge outside reset.
`define RGBCF_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define RGBCF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> hw/rtl/rgbcf_pkg.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter - package
// Types, register indices, kernel codes and the per-channel arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbcf_pkg;

    localparam int CFG_W   = 11;
    localparam int CFG_MAX = (1 << CFG_W) - 1;
    localparam int IDX_W   = 3;
    localparam int CH_W    = 8;
    localparam int SUM_W   = 14;
    localparam int BACK_W  = CFG_W + 2;

    // Box blur: floor(n / 9) as (n * ceil(2^16 / 9)) >> 16, exact for n < 2^15.
    localparam int BOX_N_W     = 12;
    localparam int BOX_RECIP_W = 13;
    localparam int BOX_SHIFT   = 16;

    typedef logic [CFG_W-1:0]       t_cfg;
    typedef logic [CFG_W:0]         t_cfg_x;
    typedef logic [IDX_W-1:0]       t_reg_idx;
    typedef logic [1:0]             t_mode;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic [8:0][CH_W-1:0]   t_taps;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix;

    localparam t_reg_idx REG_IMAGE_WIDTH  = 3'd0;
    localparam t_reg_idx REG_IMAGE_HEIGHT = 3'd1;
    localparam t_reg_idx REG_SEL_LEFT     = 3'd2;
    localparam t_reg_idx REG_SEL_TOP      = 3'd3;
    localparam t_reg_idx REG_SEL_RIGHT    = 3'd4;
    localparam t_reg_idx REG_SEL_BOTTOM   = 3'd5;
    localparam t_reg_idx REG_FILTER_MODE  = 3'd6;

    localparam t_mode MODE_EDGE    = 2'd0;
    localparam t_mode MODE_SHARPEN = 2'd1;
    localparam t_mode MODE_BOX     = 2'd2;
    localparam t_mode MODE_GAUSS   = 2'd3;

    localparam t_cfg CFG_ONE       = 11'd1;
    localparam t_cfg RST_WIDTH     = 11'd1024;
    localparam t_cfg RST_HEIGHT    = 11'd1024;
    localparam t_cfg RST_SEL_LEFT  = 11'd0;
    localparam t_cfg RST_SEL_TOP   = 11'd0;
    localparam t_cfg RST_SEL_RIGHT = 11'd1024;
    localparam t_cfg RST_SEL_BOT   = 11'd1024;

    localparam logic [BOX_RECIP_W-1:0] BOX_RECIP = 13'd7282;

    // Exact kernel sum of one channel; taps run row by row, top left first.
    function automatic t_sum conv_sum(input t_mode mode, input t_taps t);
        t_sum v [9];
        t_sum s;
        for (int n = 0; n < 9; n++) begin
            v[n] = signed'({{(SUM_W - CH_W){1'b0}}, t[n]});
        end
        case (mode)
            MODE_EDGE: begin
                s = (v[4] <<< 3) - v[0] - v[1] - v[2] - v[3] - v[5] - v[6] - v[7] - v[8];
            end
            MODE_SHARPEN: begin
                s = (v[4] <<< 2) + v[4] - v[1] - v[3] - v[5] - v[7];
            end
            MODE_BOX: begin
                s = v[0] + v[1] + v[2] + v[3] + v[4] + v[5] + v[6] + v[7] + v[8];
            end
            MODE_GAUSS: begin
                s = v[0] + (v[1] <<< 1) + v[2] + (v[3] <<< 1) + (v[4] <<< 2)
                    + (v[5] <<< 1) + v[6] + (v[7] <<< 1) + v[8];
            end
            default: begin
                s = '0;
            end
        endcase
        return s;
    endfunction

    // Rounding half up for the blurs, then clamping to the channel range.
    function automatic logic [CH_W-1:0] round_clamp(input t_mode mode, input t_sum s);
        t_sum                               n;
        t_sum                               q;
        logic [BOX_N_W+BOX_RECIP_W-1:0]     prod;
        n    = s + t_sum'(4);
        prod = n[BOX_N_W-1:0] * BOX_RECIP;
        case (mode)
            MODE_BOX: begin
                q = signed'({{(SUM_W - CH_W){1'b0}}, prod[BOX_SHIFT +: CH_W]});
            end
            MODE_GAUSS: begin
                q = (s + t_sum'(8)) >>> 4;
            end
            default: begin
                q = s;
            end
        endcase
        if (q < 0) begin
            return '0;
        end else if (q > t_sum'(255)) begin
            return '1;
        end
        return q[CH_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rgbcf_ram.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter - generic RAM
// One write port and two read ports, read data registered on read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbcf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2051,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rgb_3x3_convolution_filter_core.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter core
// Streams RGB pixels through a line history and replaces selected interior
// pixels by an edge, sharpen, box or Gaussian 3x3 kernel per channel.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  cfg       in         i_cfg_we                   i_cfg_index, i_cfg_data
//  in        in         i_in_valid / o_in_stall    i_in_red/green/blue, i_is_padding
//  out       out        o_out_valid / i_out_stall  o_out_red/green/blue, o_frame_end
//
//  One request is taken every cycle while the input is not stalled; its result passes through stages 1, 2 and 3.
//  The six upper window taps come from three copies of the line store, each
//  read at two addresses per cycle, so the rate is set by those read ports.
//  Reset clears counters, write pointer and stage valids and loads the configuration defaults;
//  data registers and the line store are not cleared and need no clearing pass.
//  Input stalls only when all three stages hold a result and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_3x3_convolution_filter_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire rgbcf_pkg::t_reg_idx     i_cfg_index,
    input  wire rgbcf_pkg::t_cfg         i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [rgbcf_pkg::CH_W-1:0] i_in_red,
    input  wire logic [rgbcf_pkg::CH_W-1:0] i_in_green,
    input  wire logic [rgbcf_pkg::CH_W-1:0] i_in_blue,
    input  wire logic                    i_is_padding,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [rgbcf_pkg::CH_W-1:0]   o_out_red,
    output logic [rgbcf_pkg::CH_W-1:0]   o_out_green,
    output logic [rgbcf_pkg::CH_W-1:0]   o_out_blue,
    output logic                         o_frame_end
);

    import rgbcf_pkg::*;

    localparam int W_CAP      = (MAX_WIDTH > CFG_MAX) ? CFG_MAX : MAX_WIDTH;
    localparam int H_CAP      = (MAX_HEIGHT > CFG_MAX) ? CFG_MAX : MAX_HEIGHT;
    localparam int HIST_DEPTH = 2 * MAX_WIDTH + 3;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);
    localparam int XW         = ((ADDR_W > BACK_W) ? ADDR_W : BACK_W) + 1;

    localparam t_cfg              W_CAP_V  = t_cfg'(W_CAP);
    localparam t_cfg              H_CAP_V  = t_cfg'(H_CAP);
    localparam logic [ADDR_W-1:0] WP_LAST  = ADDR_W'(HIST_DEPTH - 1);
    localparam logic [ADDR_W-1:0] WP_ONE   = ADDR_W'(1);

    // Position of the entry written `back' requests ago in the ring.
    function automatic logic [ADDR_W-1:0] hist_addr(input logic [ADDR_W-1:0] wp,
                                                    input logic [BACK_W-1:0] back);
        logic [XW-1:0] d;
        d = XW'(wp) - XW'(back);
        if (d[XW-1]) begin
            d = d + XW'(HIST_DEPTH);
        end
        return d[ADDR_W-1:0];
    endfunction

    // Configuration registers
    t_cfg  r_image_width;
    t_cfg  r_image_height;
    t_cfg  r_sel_left;
    t_cfg  r_sel_top;
    t_cfg  r_sel_right;
    t_cfg  r_sel_bottom;
    t_mode r_filter_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_WIDTH;
            r_image_height <= RST_HEIGHT;
            r_sel_left     <= RST_SEL_LEFT;
            r_sel_top      <= RST_SEL_TOP;
            r_sel_right    <= RST_SEL_RIGHT;
            r_sel_bottom   <= RST_SEL_BOT;
            r_filter_mode  <= MODE_EDGE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                REG_SEL_LEFT:     r_sel_left     <= i_cfg_data;
                REG_SEL_TOP:      r_sel_top      <= i_cfg_data;
                REG_SEL_RIGHT:    r_sel_right    <= i_cfg_data;
                REG_SEL_BOTTOM:   r_sel_bottom   <= i_cfg_data;
                REG_FILTER_MODE:  r_filter_mode  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    t_cfg w_eff;
    t_cfg h_eff;

    always_comb begin
        if (r_image_width == '0) begin
            w_eff = CFG_ONE;
        end else if (r_image_width > W_CAP_V) begin
            w_eff = W_CAP_V;
        end else begin
            w_eff = r_image_width;
        end
        if (r_image_height == '0) begin
            h_eff = CFG_ONE;
        end else if (r_image_height > H_CAP_V) begin
            h_eff = H_CAP_V;
        end else begin
            h_eff = r_image_height;
        end
    end

    // Pipeline control: each stage moves on when the one after it is free.
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic en1;
    logic en2;
    logic en3;

    assign en3        = !r_v3 || !i_out_stall;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_in_stall = !en1;

    // Stream position and ring state
    t_cfg              r_in_column;
    t_cfg              r_in_row;
    t_cfg              r_out_column;
    t_cfg              r_out_row;
    logic [ADDR_W-1:0] r_wp;
    t_cfg              n_in_column;
    t_cfg              n_in_row;
    t_cfg              n_out_column;
    t_cfg              n_out_row;
    logic [ADDR_W-1:0] n_wp;

    t_pix pix_in;
    t_pix wval;
    logic in_frame;
    logic take;
    logic emit;
    logic in_col_wrap;
    logic out_col_wrap;
    logic out_last;
    logic filt;

    assign pix_in   = '{red: i_in_red, green: i_in_green, blue: i_in_blue};
    assign in_frame = r_in_row < h_eff;
    assign wval     = in_frame ? pix_in : '0;
    // Padding that arrives while frame pixels are still due is dropped silently.
    assign take     = i_in_valid && en1 && !(in_frame && i_is_padding);
    assign emit     = (r_in_row >= t_cfg'(2)) || (r_in_row == CFG_ONE && r_in_column != '0);
    assign n_wp     = (r_wp >= WP_LAST) ? '0 : r_wp + WP_ONE;

    assign in_col_wrap  = (t_cfg_x'(r_in_column) + t_cfg_x'(1)) >= t_cfg_x'(w_eff);
    assign out_col_wrap = (t_cfg_x'(r_out_column) + t_cfg_x'(1)) >= t_cfg_x'(w_eff);
    assign out_last     = out_col_wrap &&
                          ((t_cfg_x'(r_out_row) + t_cfg_x'(1)) >= t_cfg_x'(h_eff));

    assign filt = (r_out_row != '0) && (r_out_column != '0) &&
                  ((t_cfg_x'(r_out_row) + t_cfg_x'(2)) <= t_cfg_x'(h_eff)) &&
                  ((t_cfg_x'(r_out_column) + t_cfg_x'(2)) <= t_cfg_x'(w_eff)) &&
                  (r_out_row >= r_sel_top) && (r_out_row < r_sel_bottom) &&
                  (r_out_column >= r_sel_left) && (r_out_column < r_sel_right);

    always_comb begin
        n_in_column  = r_in_column;
        n_in_row     = r_in_row;
        n_out_column = r_out_column;
        n_out_row    = r_out_row;
        if (take) begin
            if (in_col_wrap) begin
                n_in_column = '0;
                n_in_row    = r_in_row + CFG_ONE;
            end else begin
                n_in_column = r_in_column + CFG_ONE;
            end
            if (emit) begin
                if (out_last) begin
                    n_in_column  = '0;
                    n_in_row     = '0;
                    n_out_column = '0;
                    n_out_row    = '0;
                end else if (out_col_wrap) begin
                    n_out_column = '0;
                    n_out_row    = r_out_row + CFG_ONE;
                end else begin
                    n_out_column = r_out_column + CFG_ONE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_column  <= '0;
            r_in_row     <= '0;
            r_out_column <= '0;
            r_out_row    <= '0;
            r_wp         <= '0;
        end else begin
            r_in_column  <= n_in_column;
            r_in_row     <= n_in_row;
            r_out_column <= n_out_column;
            r_out_row    <= n_out_row;
            if (take) begin
                r_wp <= n_wp;
            end
        end
    end

    // The two most recent entries also sit in registers for the lower row.
    t_pix r_hist1;
    t_pix r_hist2;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_hist1 <= wval;
            r_hist2 <= r_hist1;
        end
    end

    // Upper and middle window rows: taps 2w+2, 2w+1, 2w, w+2, w+1 and w back.
    logic [BACK_W-1:0] bw;
    logic [BACK_W-1:0] b2w;
    logic [BACK_W-1:0] back    [6];
    logic [ADDR_W-1:0] rd_addr [6];
    t_pix              ram_q   [6];

    assign bw      = {2'b00, w_eff};
    assign b2w     = {1'b0, w_eff, 1'b0};
    assign back[0] = b2w + BACK_W'(2);
    assign back[1] = b2w + BACK_W'(1);
    assign back[2] = b2w;
    assign back[3] = bw + BACK_W'(2);
    assign back[4] = bw + BACK_W'(1);
    assign back[5] = bw;

    for (genvar g = 0; g < 6; g++) begin : g_addr
        assign rd_addr[g] = hist_addr(n_wp, back[g]);
    end

    for (genvar g = 0; g < 3; g++) begin : g_bank
        rgbcf_ram #(
            .WIDTH ($bits(t_pix)),
            .DEPTH (HIST_DEPTH)
        ) u_ram (
            .i_clk     (i_clk),
            .i_we      (take),
            .i_waddr   (n_wp),
            .i_wdata   (wval),
            .i_re      (take),
            .i_raddr_a (rd_addr[2*g]),
            .i_raddr_b (rd_addr[2*g+1]),
            .o_rdata_a (ram_q[2*g]),
            .o_rdata_b (ram_q[2*g+1])
        );
    end

    // Stage 1: RAM data arrives alongside the lower row and the decisions.
    logic  r_filt1;
    logic  r_last1;
    t_mode r_mode1;
    t_pix  r_low1 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= take && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_filt1   <= filt;
            r_last1   <= out_last;
            r_mode1   <= r_filter_mode;
            r_low1[0] <= r_hist2;
            r_low1[1] <= r_hist1;
            r_low1[2] <= wval;
        end
    end

    t_pix  win [9];
    t_taps taps_red;
    t_taps taps_green;
    t_taps taps_blue;

    always_comb begin
        for (int n = 0; n < 6; n++) begin
            win[n] = ram_q[n];
        end
        for (int n = 0; n < 3; n++) begin
            win[6+n] = r_low1[n];
        end
        for (int n = 0; n < 9; n++) begin
            taps_red[n]   = win[n].red;
            taps_green[n] = win[n].green;
            taps_blue[n]  = win[n].blue;
        end
    end

    // Stage 2: exact kernel sums per channel.
    logic  r_filt2;
    logic  r_last2;
    t_mode r_mode2;
    t_pix  r_center2;
    t_sum  r_sum_red2;
    t_sum  r_sum_green2;
    t_sum  r_sum_blue2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_filt2      <= r_filt1;
            r_last2      <= r_last1;
            r_mode2      <= r_mode1;
            r_center2    <= win[4];
            r_sum_red2   <= conv_sum(r_mode1, taps_red);
            r_sum_green2 <= conv_sum(r_mode1, taps_green);
            r_sum_blue2  <= conv_sum(r_mode1, taps_blue);
        end
    end

    // Stage 3: rounding, clamping and the pass-through choice into the output.
    t_pix r_out_pix;
    logic r_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_frame_end <= r_last2;
            if (r_filt2) begin
                r_out_pix.red   <= round_clamp(r_mode2, r_sum_red2);
                r_out_pix.green <= round_clamp(r_mode2, r_sum_green2);
                r_out_pix.blue  <= round_clamp(r_mode2, r_sum_blue2);
            end else begin
                r_out_pix <= r_center2;
            end
        end
    end

    assign o_out_valid = r_v3;
    assign o_out_red   = r_out_pix.red;
    assign o_out_green = r_out_pix.green;
    assign o_out_blue  = r_out_pix.blue;
    assign o_frame_end = r_frame_end;

endmodule

`default_nettype wire

>>> hw/rtl/rgbcf_checker.sv
// ----------------------------------------------------------------------------
// RGB 3x3 convolution filter - port checker
// Watches the core's ports over time; bound to every instance of the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_3x3_convolution_filter_core_macros.svh"

module rgbcf_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_in_stall,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic [rgbcf_pkg::CH_W-1:0]   o_out_red,
    input wire logic [rgbcf_pkg::CH_W-1:0]   o_out_green,
    input wire logic [rgbcf_pkg::CH_W-1:0]   o_out_blue,
    input wire logic                         o_frame_end
);

    `RGBCF_ASSERT_RST(a_out_valid_held, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "output request dropped while stalled")
    `RGBCF_ASSERT_RST(a_out_data_held, i_clk, i_rst_n, o_out_valid && i_out_stall |=> $stable({o_out_red, o_out_green, o_out_blue, o_frame_end}), "output payload changed while stalled")
    // The input side only backs up once the output is full and blocked.
    `RGBCF_ASSERT_RST(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall, "input stalled while the output could move")
    `RGBCF_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "pipeline not empty after reset")

endmodule

bind rgb_3x3_convolution_filter_core rgbcf_checker u_rgbcf_checker (.*);

`default_nettype wire
